FILE: hdl/sia_pkg.sv
// Shared constants, types and the arctangent table for segment_include_angle.
// Depends on nothing; every other file of the block but sia_if uses it.
package sia_pkg;

  localparam int CoordWidthDef  = 24;
  localparam int CordicStepsDef = 16;
  localparam int AtanEntries    = 24;
  localparam int ScaleWidth     = 16;
  localparam int AngleWidth     = 15;
  localparam int ZWidth         = 26;
  localparam int CWidth         = 31;
  localparam int QueueDepth     = 4;
  localparam logic [ScaleWidth-1:0] ScaleReset = 16'd256;
  localparam logic signed [ZWidth-1:0] Deg90  = 26'sd5898240;
  localparam logic signed [ZWidth-1:0] Deg180 = 26'sd11796480;
  localparam logic [AngleWidth-1:0] AngleMax = 15'd23040;

  // Result of the front part: the normalized vector and start angle handed to the CORDIC.
  typedef struct packed {
    logic                     zero_out;
    logic                     degen;
    logic signed [CWidth-1:0] x;
    logic signed [CWidth-1:0] y;
    logic signed [ZWidth-1:0] z;
  } job_t;

  // Arctangent of 2^-i in degrees, Q.16, rounded.
  function automatic logic signed [ZWidth-1:0] atan_deg(input int i);
    logic signed [ZWidth-1:0] r;
    case (i)
      0: r = 26'sd2949120;  1: r = 26'sd1740967;  2: r = 26'sd919879;
      3: r = 26'sd466945;   4: r = 26'sd234379;   5: r = 26'sd117304;
      6: r = 26'sd58666;    7: r = 26'sd29335;    8: r = 26'sd14668;
      9: r = 26'sd7334;     10: r = 26'sd3667;    11: r = 26'sd1833;
      12: r = 26'sd917;     13: r = 26'sd458;     14: r = 26'sd229;
      15: r = 26'sd115;     16: r = 26'sd57;      17: r = 26'sd29;
      18: r = 26'sd14;      19: r = 26'sd7;       20: r = 26'sd4;
      21: r = 26'sd2;       22: r = 26'sd1;       default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/sia_if.sv
// Valid/ready channel interfaces for the segment pair and the angle result.
// Depends on nothing but the port widths handed in.
interface sia_in_if #(parameter int CW = 24);
  logic valid;
  logic ready;
  logic signed [CW-1:0] first_start_x, first_start_y, first_end_x, first_end_y;
  logic signed [CW-1:0] second_start_x, second_start_y, second_end_x, second_end_y;
  logic has_second;
  modport source(output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                 second_start_x, second_start_y, second_end_x, second_end_y,
                 has_second, input ready);
  modport sink(input valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
               has_second, output ready);
endinterface

interface sia_out_if;
  logic valid;
  logic ready;
  logic [14:0] angle_deg;
  logic degenerate;
  modport source(output valid, angle_deg, degenerate, input ready);
  modport sink(input valid, angle_deg, degenerate, output ready);
endinterface

FILE: hdl/sia_front.sv
// Front part: differences, scaling, normalizing, cross and dot products.
// Depends on sia_pkg. Pipelined, one item per cycle while adv_i is high, four register stages.
module sia_front #(
  parameter int CW = sia_pkg::CoordWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic in_valid_i,
  input  logic [sia_pkg::ScaleWidth-1:0] y_scale_i,
  input  logic signed [CW-1:0] c_i [8],
  input  logic has_second_i,
  output logic out_valid_o,
  output sia_pkg::job_t job_o
);
  localparam int DW = CW + 1;
  localparam int PW = DW + 17;
  localparam int NW = 31;
  localparam int MW = 63;

  function automatic logic signed [NW-1:0] norm_lim(input logic signed [MW-1:0] v,
                                                    input logic [5:0] s);
    logic [MW-1:0] m;
    m = v[MW-1] ? MW'(-v) : MW'(v);
    m = m >> s;
    return v[MW-1] ? -NW'(m) : NW'(m);
  endfunction

  function automatic logic [5:0] shamt(input logic signed [MW-1:0] a,
                                       input logic signed [MW-1:0] b, input int lim);
    logic [MW-1:0] ma, mb, m;
    logic [5:0] s;
    ma = a[MW-1] ? MW'(-a) : MW'(a);
    mb = b[MW-1] ? MW'(-b) : MW'(b);
    m = (ma > mb) ? ma : mb;
    s = '0;
    for (int k = 0; k < MW; k++) if (m[k] && k + 1 > lim + s) s = 6'(k + 1 - lim);
    return s;
  endfunction

  // Stage 1: scaled direction components.
  logic v1_q, z1_q;
  logic signed [PW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [DW-1:0] dax, day, dbx, dby;
  always_comb begin
    dax = DW'(c_i[2]) - DW'(c_i[0]);
    day = DW'(c_i[3]) - DW'(c_i[1]);
    dbx = DW'(c_i[6]) - DW'(c_i[4]);
    dby = DW'(c_i[7]) - DW'(c_i[5]);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv_i) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      z1_q <= !has_second_i;
      ax_q <= PW'(dax) <<< 8;
      ay_q <= PW'(dax - dax + day) * $signed({1'b0, y_scale_i});
      bx_q <= PW'(dbx) <<< 8;
      by_q <= PW'(dby) * $signed({1'b0, y_scale_i});
    end
  end

  // Stage 2: per-vector normalization to below 2^30.
  logic v2_q, z2_q, d2_q;
  logic signed [NW-1:0] nax_q, nay_q, nbx_q, nby_q;
  logic [5:0] sa, sb;
  always_comb begin
    sa = shamt(MW'(ax_q), MW'(ay_q), 30);
    sb = shamt(MW'(bx_q), MW'(by_q), 30);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      z2_q <= z1_q;
      d2_q <= (ax_q == '0 && ay_q == '0) || (bx_q == '0 && by_q == '0);
      nax_q <= norm_lim(MW'(ax_q), sa);
      nay_q <= norm_lim(MW'(ay_q), sa);
      nbx_q <= norm_lim(MW'(bx_q), sb);
      nby_q <= norm_lim(MW'(by_q), sb);
    end
  end

  // Stage 3: four products, each registered.
  logic v3_q, z3_q, d3_q;
  logic signed [MW-1:0] p0_q, p1_q, p2_q, p3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv_i) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      z3_q <= z2_q;
      d3_q <= d2_q;
      p0_q <= MW'(nax_q) * MW'(nby_q);
      p1_q <= MW'(nay_q) * MW'(nbx_q);
      p2_q <= MW'(nax_q) * MW'(nbx_q);
      p3_q <= MW'(nay_q) * MW'(nby_q);
    end
  end

  // Stage 4: cross and dot, absolute cross.
  logic v4_q, z4_q, d4_q;
  logic signed [MW-1:0] cr_q, dt_q, crs;
  always_comb begin
    crs = p0_q - p1_q;
    if (crs[MW-1]) crs = -crs;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv_i) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      z4_q <= z3_q;
      d4_q <= d3_q;
      cr_q <= crs;
      dt_q <= p2_q + p3_q;
    end
  end

  // Normalize to below 2^28 and pick the starting quadrant.
  logic [5:0] sc;
  logic signed [NW-1:0] ncr, ndt;
  always_comb begin
    sc  = shamt(cr_q, dt_q, 28);
    ncr = norm_lim(cr_q, sc);
    ndt = norm_lim(dt_q, sc);
    job_o.zero_out = z4_q;
    job_o.degen    = d4_q;
    if (ndt[NW-1]) begin
      job_o.x = ncr;
      job_o.y = -ndt;
      job_o.z = sia_pkg::Deg90;
    end else begin
      job_o.x = ndt;
      job_o.y = ncr;
      job_o.z = '0;
    end
  end
  assign out_valid_o = v4_q;
endmodule

FILE: hdl/sia_queue.sv
// Short queue between the front and back parts.
// Depends on sia_pkg for the item type and depth.
module sia_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  sia_pkg::job_t data_i,
  input  logic pop_i,
  output logic empty_o,
  output logic [2:0] count_o,
  output sia_pkg::job_t data_o
);
  sia_pkg::job_t mem_q [sia_pkg::QueueDepth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
endmodule

FILE: hdl/sia_back.sv
// Back part: unrolled pipelined CORDIC, fold and rounding, output register.
// Depends on sia_pkg.
module sia_back #(
  parameter int STEPS = sia_pkg::CordicStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic in_valid_i,
  input  sia_pkg::job_t job_i,
  output logic out_valid_o,
  output logic [sia_pkg::AngleWidth-1:0] angle_o,
  output logic degen_o
);
  localparam int N  = (STEPS < sia_pkg::AtanEntries) ? STEPS : sia_pkg::AtanEntries;
  localparam int CW = sia_pkg::CWidth;
  localparam int ZW = sia_pkg::ZWidth;

  logic [N:0] v_q;
  sia_pkg::job_t st_q [N+1];

  // Stage input.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (adv_i) v_q[0] <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) st_q[0] <= job_i;
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_rot
    sia_pkg::job_t nx;
    always_comb begin
      nx = st_q[i];
      if (!st_q[i].y[CW-1]) begin
        nx.x = st_q[i].x + (st_q[i].y >>> i);
        nx.y = st_q[i].y - (st_q[i].x >>> i);
        nx.z = st_q[i].z + sia_pkg::atan_deg(i);
      end else begin
        nx.x = st_q[i].x - (st_q[i].y >>> i);
        nx.y = st_q[i].y + (st_q[i].x >>> i);
        nx.z = st_q[i].z - sia_pkg::atan_deg(i);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (adv_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) st_q[i+1] <= nx;
    end
  end

  // Clamp, fold, round to Q.7.
  logic signed [ZW-1:0] z;
  logic [ZW-1:0] r;
  logic [sia_pkg::AngleWidth-1:0] ang;
  always_comb begin
    z = st_q[N].z;
    if (z[ZW-1]) z = '0;
    if (z > sia_pkg::Deg180) z = sia_pkg::Deg180;
    if (z < sia_pkg::Deg90) z = sia_pkg::Deg180 - z;
    r = (ZW'(z) + ZW'(256)) >> 9;
    ang = (r > ZW'(sia_pkg::AngleMax)) ? sia_pkg::AngleMax : r[sia_pkg::AngleWidth-1:0];
    if (st_q[N].zero_out || st_q[N].degen) ang = '0;
  end
  assign out_valid_o = v_q[N];
  assign angle_o = ang;
  assign degen_o = st_q[N].degen && !st_q[N].zero_out;
endmodule

FILE: hdl/segment_include_angle.sv
// Top level of segment_include_angle: config register, front, queue, back.
// Depends on sia_pkg, sia_if, sia_front, sia_queue and sia_back.
//
// Usage: items (two segments and has_second) enter on in_ch with valid/ready;
// one result item (angle_deg in Q8.7 degrees, degenerate) leaves on out_ch.
// y_scale is written by cfg_we_i/cfg_wdata_i; the user must do so only while
// idle, which the block itself does not enforce; reset sets it to 1.0.
// Throughput is one item per cycle while results are taken. Each item passes
// the four register stages of the front part, then the CORDIC input register
// and one stage for each of the CORDIC_STEPS steps (at most 24), the last of
// which is the output register. An empty queue is bypassed.
// The back part stalls as a whole when its result is not taken. The queue
// catches the one item that leaves the front part in such a cycle. The front
// part and in_ch.ready then hold until the queue has drained.
// Reset empties all pipelines and the queue; no item is pending after it.
module segment_include_angle #(
  parameter int COORD_WIDTH  = sia_pkg::CoordWidthDef,
  parameter int CORDIC_STEPS = sia_pkg::CordicStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [sia_pkg::ScaleWidth-1:0] cfg_wdata_i,
  sia_in_if.sink in_ch,
  sia_out_if.source out_ch
);
  logic [sia_pkg::ScaleWidth-1:0] y_scale_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y_scale_q <= sia_pkg::ScaleReset;
    else if (cfg_we_i) y_scale_q <= cfg_wdata_i;
  end

  logic signed [COORD_WIDTH-1:0] c [8];
  assign c[0] = in_ch.first_start_x;  assign c[1] = in_ch.first_start_y;
  assign c[2] = in_ch.first_end_x;    assign c[3] = in_ch.first_end_y;
  assign c[4] = in_ch.second_start_x; assign c[5] = in_ch.second_start_y;
  assign c[6] = in_ch.second_end_x;   assign c[7] = in_ch.second_end_y;

  // Front pipeline: four stages; advances while the queue is empty.
  logic f_valid, q_empty, back_adv, fr_adv, pop;
  logic [2:0] q_cnt;
  sia_pkg::job_t f_job, q_job;
  assign fr_adv = (q_cnt == 3'd0);
  assign in_ch.ready = fr_adv;

  sia_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .adv_i(fr_adv), .in_valid_i(in_ch.valid), .y_scale_i(y_scale_q),
    .c_i(c), .has_second_i(in_ch.has_second), .out_valid_o(f_valid), .job_o(f_job)
  );

  // Queue takes the item that leaves the front part while the back part stalls.
  logic push;
  assign push = f_valid && (fr_adv ? !(back_adv && q_empty) : 1'b0);
  logic direct;
  assign direct = f_valid && fr_adv && back_adv && q_empty;
  assign pop = back_adv && !q_empty;

  sia_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_job), .pop_i(pop),
    .empty_o(q_empty), .count_o(q_cnt), .data_o(q_job)
  );

  // Back pipeline advances whenever its output register is free or taken.
  logic b_valid, b_degen;
  logic [sia_pkg::AngleWidth-1:0] b_angle;
  assign back_adv = !b_valid || out_ch.ready;

  sia_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .adv_i(back_adv), .in_valid_i(pop || direct),
    .job_i(q_empty ? f_job : q_job),
    .out_valid_o(b_valid), .angle_o(b_angle), .degen_o(b_degen)
  );

  assign out_ch.valid = b_valid;
  assign out_ch.angle_deg = b_angle;
  assign out_ch.degenerate = b_degen;

  // The queue never overflows and never pops while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_cnt <= 3'd4)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && direct))
    else $error("item both queued and bypassed");
endmodule
